@@ rtl/lpp_pkg.sv @@
// Shared types and constants for the lidar point pinhole projection block.
package lpp_pkg;

    localparam int COORD_W = 20;
    localparam int DEN_W   = 23;
    localparam int REM_W   = 35;
    localparam int MAG_W   = 38;
    localparam int PIX_W   = 12;
    localparam int RANGE_W = 40;

    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_BEHIND  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic [2:0] REG_ROW_X = 3'd0;
    localparam logic [2:0] REG_ROW_Y = 3'd1;
    localparam logic [2:0] REG_ROW_Z = 3'd2;
    localparam logic [2:0] REG_INTR  = 3'd3;
    localparam logic [2:0] REG_SIZE  = 3'd4;

    localparam logic [47:0] INTR_RESET = 48'h0F00_1400_0000;
    localparam logic [23:0] SIZE_RESET = 24'h1E0280;

    // One word handed from cell to cell in the divider chain.
    typedef struct packed {
        logic               behind;
        logic               neg_u;
        logic               neg_v;
        logic               ovf_u;
        logic               ovf_v;
        logic [REM_W-1:0]   rem_u;
        logic [REM_W-1:0]   rem_v;
        logic [PIX_W-1:0]   q_u;
        logic [PIX_W-1:0]   q_v;
        logic [DEN_W-1:0]   den;
        logic [RANGE_W-1:0] range_sq;
    } t_cell_word;

endpackage

@@ rtl/lpp_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit for the u and v lanes.
module lpp_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  lpp_pkg::t_cell_word i_word,
    output logic                o_valid,
    output lpp_pkg::t_cell_word o_word
);
    import lpp_pkg::*;

    logic       r_valid;
    t_cell_word r_word;
    t_cell_word n_word;
    logic [REM_W-1:0] trial;

    always_comb begin
        n_word = i_word;
        trial  = REM_W'(i_word.den) << SHIFT;
        if (i_word.rem_u >= trial) begin
            n_word.rem_u    = i_word.rem_u - trial;
            n_word.q_u[SHIFT] = 1'b1;
        end
        if (i_word.rem_v >= trial) begin
            n_word.rem_v    = i_word.rem_v - trial;
            n_word.q_v[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

@@ rtl/lidar_point_pinhole_projection.sv @@
// Top level of the lidar point pinhole projection pipeline.
// Accepts one point per cycle unless stalled and returns one word per point
// through registers for the rotation products, the rounded and saturated camera
// coordinates, the projection numerators and operand preparation, a chain
// of division cells that each settle one bit of u and v, and an output
// register. The whole pipeline holds while a finished word waits with stall
// high. The user must write registers only while idle; no logic enforces it.
module lidar_point_pinhole_projection (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [17:0]    i_point_x,
    input  logic signed [17:0]    i_point_y,
    input  logic signed [17:0]    i_point_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [11:0]           o_pixel_u,
    output logic [11:0]           o_pixel_v,
    output logic [1:0]            o_status,
    output logic [39:0]           o_range_squared
);
    import lpp_pkg::*;

    logic [63:0] r_row [3];
    logic [47:0] r_intr;
    logic [23:0] r_size;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_intr   <= INTR_RESET;
            r_size   <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_X: r_row[0] <= i_cfg_data;
                REG_ROW_Y: r_row[1] <= i_cfg_data;
                REG_ROW_Z: r_row[2] <= i_cfg_data;
                REG_INTR:  r_intr   <= i_cfg_data[47:0];
                REG_SIZE:  r_size   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Stage 1: nine rotation products.
    logic               r_v1;
    logic signed [33:0] r_p [3][3];
    logic signed [17:0] pin [3];
    assign pin[0] = i_point_x;
    assign pin[1] = i_point_y;
    assign pin[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[r][c] <= $signed(r_row[r][16*c +: 16]) * pin[c];
                end
            end
        end
    end

    // Stage 2: add translation, round half up, saturate to 20 bits.
    logic                      r_v2;
    logic signed [COORD_W-1:0] r_c [3];
    logic signed [35:0]        acc [3];
    logic signed [21:0]        rnd [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = 36'(r_p[r][0]) + 36'(r_p[r][1]) + 36'(r_p[r][2])
                   + (36'($signed(r_row[r][63:48])) <<< 14) + 36'sd8192;
            rnd[r] = 22'(acc[r] >>> 14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                if (rnd[r] > 22'sd524287) begin
                    r_c[r] <= 20'sd524287;
                end else if (rnd[r] < -22'sd524288) begin
                    r_c[r] <= -20'sd524288;
                end else begin
                    r_c[r] <= rnd[r][COORD_W-1:0];
                end
            end
        end
    end

    // Stage 3: projection terms and squares.
    logic               r_v3;
    logic signed [36:0] r_fx, r_fy, r_cxz, r_cyz;
    logic [39:0]        r_sqx, r_sqy, r_sqz;
    logic [DEN_W-1:0]   r_den3;
    logic               r_behind3;
    logic signed [16:0] f_s, cx_s, cy_s;
    logic signed [39:0] sqx, sqy, sqz;
    assign f_s  = $signed({1'b0, r_intr[15:0]});
    assign cx_s = $signed({1'b0, r_intr[31:16]});
    assign cy_s = $signed({1'b0, r_intr[47:32]});
    assign sqx  = r_c[0] * r_c[0];
    assign sqy  = r_c[1] * r_c[1];
    assign sqz  = r_c[2] * r_c[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx      <= f_s * r_c[0];
            r_fy      <= f_s * r_c[1];
            r_cxz     <= cx_s * r_c[2];
            r_cyz     <= cy_s * r_c[2];
            r_sqx     <= sqx;
            r_sqy     <= sqy;
            r_sqz     <= sqz;
            r_den3    <= {r_c[2][DEN_W-5:0], 4'b0000};
            r_behind3 <= (r_c[2] <= 20'sd0);
        end
    end

    // Stage 4: numerators and range sum.
    logic                 r_v4;
    logic signed [37:0]   r_nu, r_nv;
    logic [RANGE_W-1:0]   r_range4;
    logic [DEN_W-1:0]     r_den4;
    logic                 r_behind4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nu      <= 38'(r_fx) + 38'(r_cxz);
            r_nv      <= 38'(r_fy) + 38'(r_cyz);
            r_range4  <= r_sqx + r_sqy + r_sqz;
            r_den4    <= r_den3;
            r_behind4 <= r_behind3;
        end
    end

    // Stage 5: magnitudes and the early out-of-range test.
    logic                 r_v5;
    t_cell_word           r_w5;
    logic [MAG_W-1:0]     mag_u, mag_v, lim;
    assign mag_u = r_nu[37] ? MAG_W'(-r_nu) : MAG_W'(r_nu);
    assign mag_v = r_nv[37] ? MAG_W'(-r_nv) : MAG_W'(r_nv);
    assign lim   = MAG_W'(r_den4) << PIX_W;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w5.behind   <= r_behind4;
            r_w5.neg_u    <= r_nu[37];
            r_w5.neg_v    <= r_nv[37];
            r_w5.ovf_u    <= (mag_u >= lim);
            r_w5.ovf_v    <= (mag_v >= lim);
            r_w5.rem_u    <= mag_u[REM_W-1:0];
            r_w5.rem_v    <= mag_v[REM_W-1:0];
            r_w5.q_u      <= '0;
            r_w5.q_v      <= '0;
            r_w5.den      <= r_den4;
            r_w5.range_sq <= r_range4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Division chain, most significant quotient bit first.
    logic       cv [PIX_W+1];
    t_cell_word cw [PIX_W+1];
    assign cv[0] = r_v5;
    assign cw[0] = r_w5;

    for (genvar k = 0; k < PIX_W; k++) begin : g_div
        lpp_div_cell #(.SHIFT(PIX_W - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cv[k]),
            .i_word  (cw[k]),
            .o_valid (cv[k+1]),
            .o_word  (cw[k+1])
        );
    end

    // Output stage: classify and register the result word.
    t_cell_word fw;
    logic       outside;
    assign fw = cw[PIX_W];
    assign outside = fw.ovf_u || fw.ovf_v
                  || (fw.neg_u && fw.q_u != '0) || (fw.neg_v && fw.q_v != '0)
                  || (fw.q_u >= r_size[11:0]) || (fw.q_v >= r_size[23:12]);

    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cv[PIX_W];
        end
        if (en) begin
            if (fw.behind) begin
                o_status        <= ST_BEHIND;
                o_pixel_u       <= '0;
                o_pixel_v       <= '0;
                o_range_squared <= '0;
            end else if (outside) begin
                o_status        <= ST_OUTSIDE;
                o_pixel_u       <= '0;
                o_pixel_v       <= '0;
                o_range_squared <= '0;
            end else begin
                o_status        <= ST_INSIDE;
                o_pixel_u       <= fw.q_u;
                o_pixel_v       <= fw.q_v;
                o_range_squared <= fw.range_sq;
            end
        end
    end
    assign o_valid = r_out_valid;
endmodule

@@ tb/lidar_point_pinhole_projection_test.sv @@
// Self-checking testbench for the lidar point pinhole projection block.
module lidar_point_pinhole_projection_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpp_pkg::*;

    typedef struct packed {
        logic [11:0] u;
        logic [11:0] v;
        logic [1:0]  st;
        logic [39:0] rng;
    } t_pixel_word;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        bit                 typed;
        t_pixel_word        want;
    } t_point_row;

    localparam logic [63:0] ONE_Q14 = 64'h4000;
    localparam int          N_PHASES = 8;
    localparam int          PHASE_POINTS = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = REG_ROW_X;
    logic [63:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [17:0] i_point_x = '0;
    logic signed [17:0] i_point_y = '0;
    logic signed [17:0] i_point_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic [11:0]        o_pixel_u;
    logic [11:0]        o_pixel_v;
    logic [1:0]         o_status;
    logic [39:0]        o_range_squared;

    // Model copy of the transform and camera registers.
    logic [63:0] row_m [3];
    logic [47:0] intr_m = INTR_RESET;
    logic [23:0] size_m = SIZE_RESET;

    t_pixel_word pending_pixels [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;

    lidar_point_pinhole_projection dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        row_m[0] = '0;
        row_m[1] = '0;
        row_m[2] = '0;
    end

    // One camera axis: Q2.14 dot product plus translation, rounded half up, saturated.
    function automatic longint camera_axis(logic [63:0] row, longint x, longint y, longint z);
        longint acc;
        acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
            + longint'($signed(row[47:32])) * z + longint'($signed(row[63:48])) * 16384;
        acc = (acc + 8192) >>> 14;
        if (acc > 524287) acc = 524287;
        if (acc < -524288) acc = -524288;
        return acc;
    endfunction

    function automatic t_pixel_word project_point(logic signed [17:0] px, logic signed [17:0] py,
                                                  logic signed [17:0] pz);
        t_pixel_word r;
        longint xc, yc, zc, f, cx, cy, den, u, v, rng;
        r = '0;
        xc = camera_axis(row_m[0], px, py, pz);
        yc = camera_axis(row_m[1], px, py, pz);
        zc = camera_axis(row_m[2], px, py, pz);
        if (zc <= 0) begin
            r.st = ST_BEHIND;
            return r;
        end
        f = longint'(intr_m[15:0]);
        cx = longint'(intr_m[31:16]);
        cy = longint'(intr_m[47:32]);
        den = zc * 16;
        u = (f * xc + cx * zc) / den;
        v = (f * yc + cy * zc) / den;
        if (u < 0 || u >= longint'(size_m[11:0]) || v < 0 || v >= longint'(size_m[23:12])) begin
            r.st = ST_OUTSIDE;
            return r;
        end
        rng = xc * xc + yc * yc + zc * zc;
        r.st = ST_INSIDE;
        r.u = u[11:0];
        r.v = v[11:0];
        r.rng = rng[39:0];
        return r;
    endfunction

    // Registers change only with the pipeline empty and settled.
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        wait (pending_pixels.size() == 0);
        repeat (25) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROW_X: row_m[0] = data;
            REG_ROW_Y: row_m[1] = data;
            REG_ROW_Z: row_m[2] = data;
            REG_INTR:  intr_m = data[47:0];
            REG_SIZE:  size_m = data[23:0];
            default: ;
        endcase
    endtask

    task automatic send_point(logic signed [17:0] x, logic signed [17:0] y, logic signed [17:0] z,
                              bit typed, t_pixel_word want);
        t_pixel_word expect_word;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        do @(posedge i_clk); while (o_stall);
        expect_word = typed ? want : project_point(x, y, z);
        pending_pixels = {pending_pixels, expect_word};
    endtask

    task automatic load_camera(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                               logic [63:0] intr, logic [63:0] sz);
        i_valid <= 1'b0;
        write_reg(REG_ROW_X, rx);
        write_reg(REG_ROW_Y, ry);
        write_reg(REG_ROW_Z, rz);
        write_reg(REG_INTR, intr);
        write_reg(REG_SIZE, sz);
    endtask

    // Near-identity rotation with small random tilt and translation.
    function automatic logic [63:0] jitter_row(int axis);
        logic [63:0] r;
        r = '0;
        r[63:48] = 16'($urandom_range(0, 4000) - 2000);
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = (k == axis) ? 16'(16384 - $urandom_range(0, 800))
                                        : 16'($urandom_range(0, 1600) - 800);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= 400;
            hold_req <= 1'b0;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_word want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_pixel_u, o_pixel_v, o_status, o_range_squared};
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: u=%0d v=%0d status=%0d range=%0d",
                             got.u, got.v, got.st, got.rng);
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected u=%0d v=%0d status=%0d range=%0d, ",
                                 want.u, want.v, want.st, want.rng,
                                 "got u=%0d v=%0d status=%0d range=%0d",
                                 got.u, got.v, got.st, got.rng);
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("[lidar_point_pinhole_projection] ERROR");
        $finish;
    end

    initial begin
        t_point_row directed [];
        logic [63:0] rz_id, intr_std;
        logic signed [17:0] x, y, z;
        int depth;

        directed = '{
            '{18'sd131071, 18'sd131071, 18'sd131071, 1'b1, '{12'd0, 12'd0, ST_BEHIND, 40'd0}},
            '{-18'sd131072, -18'sd131072, -18'sd131072, 1'b1, '{12'd0, 12'd0, ST_BEHIND, 40'd0}},
            '{18'sd0, 18'sd0, 18'sd0, 1'b1, '{12'd0, 12'd0, ST_BEHIND, 40'd0}},
            '{18'sd1, -18'sd1, 18'sd1, 1'b1, '{12'd0, 12'd0, ST_BEHIND, 40'd0}},
            '{18'sd0, 18'sd0, 18'sd1000, 1'b0, '0},
            '{18'sd0, 18'sd0, 18'sd0, 1'b0, '0},
            '{18'sd0, 18'sd0, -18'sd5, 1'b0, '0},
            '{18'sd131071, 18'sd131071, 18'sd131071, 1'b0, '0},
            '{-18'sd131072, -18'sd131072, 18'sd131071, 1'b0, '0},
            '{-18'sd131072, -18'sd131072, -18'sd131072, 1'b0, '0},
            '{18'sd0, 18'sd0, 18'sd131071, 1'b0, '0},
            '{18'sd100, -18'sd100, 18'sd2000, 1'b0, '0},
            '{-18'sd400, 18'sd300, 18'sd1000, 1'b0, '0},
            '{18'sd639, 18'sd479, 18'sd1, 1'b0, '0},
            '{18'sd1, 18'sd1, 18'sd1, 1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset registers first, then a plain identity camera.
        rz_id = ONE_Q14 << 32;
        intr_std = {16'd3840, 16'd5120, 16'd8000};
        for (int i = 0; i < directed.size(); i++) begin
            if (i == 4) begin
                load_camera(ONE_Q14, ONE_Q14 << 16, rz_id, intr_std, {40'd0, SIZE_RESET});
                for (int k = 1; k <= 3; k++)
                    write_reg(REG_SIZE + 3'(k), '1);
            end
            send_point(directed[i].x, directed[i].y, directed[i].z,
                       directed[i].typed, directed[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct = (ph < 3) ? 31 : (ph < 6) ? 79 : 0;
            stall_pct = (ph < 3) ? 79 : (ph < 6) ? 31 : 0;
            case (ph)
                1: load_camera({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
                2: load_camera(jitter_row(0), jitter_row(1), jitter_row(2), '0, {40'd0, SIZE_RESET});
                3: load_camera(jitter_row(0), jitter_row(1), jitter_row(2), intr_std, '0);
                5: load_camera('1, '1, '1, '1, '1);
                6: load_camera(jitter_row(0), jitter_row(1), jitter_row(2),
                               {16'hFFFF, 16'hFFFF, 16'hFFFF}, {40'd0, 24'hFFFFFF});
                default: load_camera(jitter_row(0), jitter_row(1), jitter_row(2),
                                     {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                      16'($urandom_range(1000, 30000))},
                                     {40'd0, 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095))});
            endcase
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (ph == 7 && n == 20)
                    hold_req = 1'b1;
                if (ph == 4 && n == 100) begin
                    i_valid <= 1'b0;
                    wait (pending_pixels.size() == 0);
                    @(posedge i_clk);
                end
                if ($urandom_range(0, 99) < 75) begin
                    // Points in front of the camera, mostly within its field of view.
                    depth = $urandom_range(300, 60000);
                    z = 18'(depth);
                    x = 18'($urandom_range(0, depth) - depth / 2);
                    y = 18'($urandom_range(0, depth) - depth / 2);
                end else begin
                    x = 18'($urandom);
                    y = 18'($urandom);
                    z = 18'($urandom);
                end
                send_point(x, y, z, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        wait (pending_pixels.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("[lidar_point_pinhole_projection] OK");
        else
            $display("[lidar_point_pinhole_projection] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lpp_pkg.sv
rtl/lpp_div_cell.sv
rtl/lidar_point_pinhole_projection.sv
tb/lidar_point_pinhole_projection_test.sv
